@@ hdl/modexp_pkg.sv @@
`default_nettype none

package modexp_pkg;

   // Width of the item fields and the register
   localparam int unsigned FIELD_WIDTH = 32;

   // Default datapath width
   localparam int unsigned DEFAULT_OPERAND_WIDTH = 32;

   // Modulus after reset
   localparam logic [FIELD_WIDTH-1:0] MODULUS_RESET = 32'd2;

endpackage : modexp_pkg

`default_nettype wire

@@ hdl/modexp_mulmod.sv @@
`default_nettype none

// Interleaved bit-serial modular multiplier: one bit of op_a per cycle,
// doubling the partial product and adding op_b where the bit is set.
// op_b must be below the modulus; the product stays below it throughout.
module modexp_mulmod #(
   parameter int unsigned OPERAND_WIDTH = modexp_pkg::DEFAULT_OPERAND_WIDTH
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     start,
   input  wire logic [OPERAND_WIDTH-1:0] op_a,
   input  wire logic [OPERAND_WIDTH-1:0] op_b,
   input  wire logic [OPERAND_WIDTH-1:0] modulus,
   output logic                          done,
   output logic [OPERAND_WIDTH-1:0]      product
);
   import modexp_pkg::*;

   localparam int unsigned W  = OPERAND_WIDTH;
   localparam int unsigned CW = $clog2(W);
   localparam logic [CW-1:0] LAST_COUNT = CW'(W - 1);

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [CW-1:0] count_ff, count_in;
   logic [W-1:0]  acc_ff, acc_in;
   logic [W-1:0]  a_ff, a_in;
   logic [W-1:0]  b_ff, b_in;
   logic [W-1:0]  doubled;
   logic [W-1:0]  stepped;

   // (x + y) mod m for x, y below m, carry kept in the extra bit
   function automatic logic [W-1:0] add_mod(input logic [W-1:0] x,
                                            input logic [W-1:0] y,
                                            input logic [W-1:0] m);
      logic [W:0] sum;
      logic [W:0] diff;
      sum  = {1'b0, x} + {1'b0, y};
      diff = sum - {1'b0, m};
      if (sum >= {1'b0, m}) begin
         return diff[W-1:0];
      end
      return sum[W-1:0];
   endfunction

   // One step: double, then add op_b under the current top bit of op_a
   always_comb begin
      doubled = add_mod(acc_ff, acc_ff, modulus);
      stepped = a_ff[W-1] ? add_mod(doubled, b_ff, modulus) : doubled;
   end

   // Sequence the steps
   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      acc_in   = acc_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      if (start) begin
         busy_in  = 1'b1;
         count_in = LAST_COUNT;
         acc_in   = '0;
         a_in     = op_a;
         b_in     = op_b;
      end else if (busy_ff) begin
         acc_in = stepped;
         a_in   = {a_ff[W-2:0], 1'b0};
         if (count_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            count_in = count_ff - CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      count_ff <= count_in;
      acc_ff   <= acc_in;
      a_ff     <= a_in;
      b_ff     <= b_in;
   end

   assign done    = done_ff;
   assign product = acc_ff;

endmodule : modexp_mulmod

`default_nettype wire

@@ hdl/modular_exponentiation.sv @@
`default_nettype none

// Channel   Direction  Handshake           Payload
// req       in         req_valid/req_stall req_base_value, req_exponent_value
// rsp       out        rsp_valid/rsp_stall rsp_power_result
// csr       in         csr_wen             csr_wdata (modulus)
//
// W = OPERAND_WIDTH. An item runs from acceptance to a valid result as a base reduction,
// then a square per exponent bit and a multiply per set bit, each in the one shared
// bit-serial multiplier. A modulus below two gives 0 without using the multiplier.
// req_stall is high until the result is loaded; a result held by rsp_stall only delays
// the finish of the next item.
// Synchronous active-high reset; the modulus resets to two.
module modular_exponentiation #(
   parameter int unsigned OPERAND_WIDTH = modexp_pkg::DEFAULT_OPERAND_WIDTH
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic [modexp_pkg::FIELD_WIDTH-1:0]  req_base_value,
   input  wire logic [modexp_pkg::FIELD_WIDTH-1:0]  req_exponent_value,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic [modexp_pkg::FIELD_WIDTH-1:0]       rsp_power_result,
   input  wire logic                                csr_wen,
   input  wire logic [modexp_pkg::FIELD_WIDTH-1:0]  csr_wdata
);
   import modexp_pkg::*;

   localparam int unsigned W  = OPERAND_WIDTH;
   localparam int unsigned CW = $clog2(W);
   localparam logic [CW-1:0] LAST_BIT = CW'(W - 1);
   localparam logic [W-1:0]  ONE      = W'(1);
   localparam logic [W-1:0]  TWO      = W'(2);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_REDUCE = 3'd1;
   localparam logic [2:0] ST_SQUARE = 3'd2;
   localparam logic [2:0] ST_MULT   = 3'd3;
   localparam logic [2:0] ST_FINISH = 3'd4;

   logic [2:0]             state_ff, state_in;
   logic [W-1:0]           modulus_ff, modulus_in;
   logic [W-1:0]           base_ff, base_in;
   logic [W-1:0]           expo_ff, expo_in;
   logic [CW-1:0]          bit_ff, bit_in;
   logic [W-1:0]           acc_ff, acc_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [FIELD_WIDTH-1:0] rsp_result_ff, rsp_result_in;

   logic                   mul_start;
   logic [W-1:0]           mul_a;
   logic [W-1:0]           mul_b;
   logic                   mul_done;
   logic [W-1:0]           mul_product;
   logic                   req_take;
   logic                   out_free;

   modexp_mulmod #(
      .OPERAND_WIDTH(W)
   ) u_mulmod (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .modulus (modulus_ff),
      .done    (mul_done),
      .product (mul_product)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && (state_ff == ST_IDLE);
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // Take register writes
   always_comb begin
      modulus_in = modulus_ff;
      if (csr_wen) begin
         modulus_in = W'(csr_wdata);
      end
   end

   // Sequence: reduce base, then square per exponent bit and multiply per set bit
   always_comb begin
      state_in      = state_ff;
      base_in       = base_ff;
      expo_in       = expo_ff;
      bit_in        = bit_ff;
      acc_in        = acc_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_result_in = rsp_result_ff;
      mul_start     = 1'b0;
      mul_a         = mul_product;
      mul_b         = mul_product;
      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               expo_in = W'(req_exponent_value);
               bit_in  = LAST_BIT;
               if (modulus_ff < TWO) begin
                  acc_in   = '0;
                  state_in = ST_FINISH;
               end else begin
                  // base mod m as base times one
                  mul_start = 1'b1;
                  mul_a     = W'(req_base_value);
                  mul_b     = ONE;
                  state_in  = ST_REDUCE;
               end
            end
         end
         ST_REDUCE: begin
            if (mul_done) begin
               base_in   = mul_product;
               mul_start = 1'b1;
               mul_a     = ONE;
               mul_b     = ONE;
               state_in  = ST_SQUARE;
            end
         end
         ST_SQUARE: begin
            if (mul_done) begin
               acc_in = mul_product;
               if (expo_ff[W-1]) begin
                  mul_start = 1'b1;
                  mul_b     = base_ff;
                  state_in  = ST_MULT;
               end else if (bit_ff == '0) begin
                  state_in = ST_FINISH;
               end else begin
                  bit_in    = bit_ff - CW'(1);
                  expo_in   = {expo_ff[W-2:0], 1'b0};
                  mul_start = 1'b1;
               end
            end
         end
         ST_MULT: begin
            if (mul_done) begin
               acc_in = mul_product;
               if (bit_ff == '0) begin
                  state_in = ST_FINISH;
               end else begin
                  bit_in    = bit_ff - CW'(1);
                  expo_in   = {expo_ff[W-2:0], 1'b0};
                  mul_start = 1'b1;
                  state_in  = ST_SQUARE;
               end
            end
         end
         ST_FINISH: begin
            // Hold until the output register is free
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_result_in = FIELD_WIDTH'(acc_ff);
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         modulus_ff   <= W'(MODULUS_RESET);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         modulus_ff   <= modulus_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      base_ff       <= base_in;
      expo_ff       <= expo_in;
      bit_ff        <= bit_in;
      acc_ff        <= acc_in;
      rsp_result_ff <= rsp_result_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_power_result = rsp_result_ff;

endmodule : modular_exponentiation

`default_nettype wire

@@ dv/modular_exponentiation_tb.sv @@
`default_nettype none

module modular_exponentiation_tb;

   import modexp_pkg::*;

   localparam int unsigned OPERAND_WIDTH   = DEFAULT_OPERAND_WIDTH;
   localparam int unsigned PHASE_COUNT     = 7;
   localparam int unsigned ITEMS_PER_PHASE = 33;
   localparam int unsigned BURST_ITEMS     = 28;
   // Let at least the longest time that one item can take pass again at the end
   localparam int unsigned SETTLE_CYCLES   = (2 * OPERAND_WIDTH + 1) * (OPERAND_WIDTH + 2) + 64;

   typedef logic [FIELD_WIDTH-1:0] word_type;

   typedef struct {
      word_type base;
      word_type exponent;
      word_type modulus;
      word_type power;
   } power_check_type;

   logic     clock              = 1'b0;
   logic     reset              = 1'b1;
   logic     req_valid          = 1'b0;
   logic     req_stall;
   word_type req_base_value     = '0;
   word_type req_exponent_value = '0;
   logic     rsp_valid;
   logic     rsp_stall          = 1'b0;
   word_type rsp_power_result;
   logic     csr_wen            = 1'b0;
   word_type csr_wdata          = '0;

   power_check_type pending_powers[$];
   word_type        modulus_setting = MODULUS_RESET;
   bit              quiet_tail      = 1'b0;
   int unsigned     items_sent      = 0;
   int unsigned     results_checked = 0;
   int unsigned     mismatch_count  = 0;
   int unsigned     modulus_writes  = 0;

   modular_exponentiation dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_base_value     (req_base_value),
      .req_exponent_value (req_exponent_value),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_power_result   (rsp_power_result),
      .csr_wen            (csr_wen),
      .csr_wdata          (csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // (x + y) mod m for x, y below m, keeping the carry
   function automatic word_type mod_add(input word_type x, input word_type y,
                                        input word_type m);
      logic [FIELD_WIDTH:0] sum;
      sum = {1'b0, x} + {1'b0, y};
      if (sum >= {1'b0, m}) sum = sum - {1'b0, m};
      return sum[FIELD_WIDTH-1:0];
   endfunction

   // Interleaved shift-and-add product, MSB of a first
   function automatic word_type mod_mul(input word_type a, input word_type b,
                                        input word_type m);
      word_type acc;
      acc = '0;
      for (int i = OPERAND_WIDTH - 1; i >= 0; i--) begin
         acc = mod_add(acc, acc, m);
         if (a[i]) acc = mod_add(acc, b, m);
      end
      return acc;
   endfunction

   // Left-to-right square-and-multiply over every exponent bit
   function automatic word_type predict_power(input word_type base, input word_type exponent,
                                              input word_type m);
      word_type acc;
      word_type reduced;
      if (m < 2) return '0;
      reduced = base % m;
      acc     = 1 % m;
      for (int i = OPERAND_WIDTH - 1; i >= 0; i--) begin
         acc = mod_mul(acc, acc, m);
         if (exponent[i]) acc = mod_mul(acc, reduced, m);
      end
      return acc;
   endfunction

   // Offer one item, log its power once taken, then maybe idle
   task automatic send_operands(input word_type base, input word_type exponent);
      power_check_type entry;
      req_valid          <= 1'b1;
      req_base_value     <= base;
      req_exponent_value <= exponent;
      do @(posedge clock); while (req_stall);
      entry.base     = base;
      entry.exponent = exponent;
      entry.modulus  = modulus_setting;
      entry.power    = predict_power(base, exponent, modulus_setting);
      pending_powers.insert(pending_powers.size(), entry);
      items_sent++;
      if (!quiet_tail && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
   endtask

   // Drop valid and hold until every logged power has come back
   task automatic wait_for_results();
      req_valid <= 1'b0;
      while (pending_powers.size() != 0) @(posedge clock);
   endtask

   task automatic write_modulus(input word_type value);
      wait_for_results();
      repeat (2) @(posedge clock);
      csr_wen   <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_wen         <= 1'b0;
      modulus_setting  = value;
      modulus_writes++;
   endtask

   // Mostly full-range operands, with some small exponents, bases near the modulus and bases of 0 or 1
   task automatic send_random_operands();
      word_type base;
      word_type exponent;
      base     = $urandom();
      exponent = $urandom();
      case ($urandom_range(0, 9))
         0: exponent = $urandom_range(0, 3);
         1: base = modulus_setting - $urandom_range(0, 2);
         2: base = modulus_setting + $urandom_range(0, 2);
         3: base = $urandom_range(0, 1);
         default: ;
      endcase
      send_operands(base, exponent);
   endtask

   // Reset modulus of two, before any write
   task automatic test_reset_modulus();
      send_operands(32'd0, 32'd0);
      send_operands(32'd5, 32'd0);
      send_operands(32'd7, 32'd3);
      send_operands(32'd8, 32'd5);
   endtask

   // Moduli of zero and one must give zero everywhere
   task automatic test_out_of_range_modulus();
      write_modulus(32'd0);
      send_operands(32'd3, 32'd5);
      send_operands(32'd0, 32'd0);
      write_modulus(32'd1);
      send_operands(32'hFFFF_FFFF, 32'd0);
      send_operands(32'd2, 32'd2);
   endtask

   task automatic test_field_extremes();
      write_modulus(32'hFFFF_FFFF);
      send_operands(32'd0, 32'd0);
      send_operands(32'd0, 32'd1);
      send_operands(32'd0, 32'hFFFF_FFFF);
      send_operands(32'd1, 32'hFFFF_FFFF);
      send_operands(32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_operands(32'hFFFF_FFFE, 32'd2);
      send_operands(32'hFFFF_FFFE, 32'hFFFF_FFFF);
      send_operands(32'h8000_0000, 32'h8000_0000);
      // largest 32-bit prime: Fermat case, base equal to modulus, base just above
      write_modulus(32'hFFFF_FFFB);
      send_operands(32'd2, 32'hFFFF_FFFA);
      send_operands(32'hFFFF_FFFB, 32'd7);
      send_operands(32'hFFFF_FFFC, 32'hFFFF_FFFF);
      send_operands(32'h1234_5678, 32'd0);
      send_operands(32'hDEAD_BEEF, 32'd1);
      write_modulus(32'd2);
      send_operands(32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_operands(32'hFFFF_FFFE, 32'd1);
   endtask

   task automatic test_random_phases();
      word_type value;
      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         case (phase)
            0: value = $urandom_range(2, 255);
            1: value = 32'hFFFF_FFFB;
            2: value = $urandom() | 32'h8000_0000;
            3: value = $urandom_range(2, 65535);
            4: value = 32'hFFFF_FFFF;
            5: value = $urandom() | 32'd1;
            default: value = $urandom();
         endcase
         if (value < 2) value = 32'd3;
         write_modulus(value);
         for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
            // in phase 0 and at random after it, pause the sender mid-phase until the block has emptied
            if (i == ITEMS_PER_PHASE / 2 && (phase == 0 || $urandom_range(0, 1) == 1))
               wait_for_results();
            send_random_operands();
         end
      end
   endtask

   // Back-to-back items with no idling on either side
   task automatic test_back_to_back();
      write_modulus($urandom() | 32'h0001_0001);
      quiet_tail = 1'b1;
      for (int i = 0; i < BURST_ITEMS; i++) send_random_operands();
   endtask

   // Result-side stall bursts between random gaps, off during the back-to-back tail
   initial begin
      int unsigned burst_left;
      burst_left = 0;
      forever begin
         @(posedge clock);
         if (burst_left != 0) begin
            burst_left--;
         end else if (rsp_stall || quiet_tail) begin
            rsp_stall  <= 1'b0;
            burst_left  = $urandom_range(0, 30);
         end else begin
            rsp_stall  <= 1'b1;
            burst_left  = $urandom_range(0, 15);
         end
      end
   end

   // Compare each accepted result with the oldest logged power
   always @(posedge clock) begin
      power_check_type oldest;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_powers.size() == 0) begin
            $display("%0t: unexpected result: expected none, actual %h",
                     $time, rsp_power_result);
            mismatch_count++;
         end else begin
            oldest = pending_powers.pop_front();
            results_checked++;
            if (rsp_power_result !== oldest.power) begin
               $display("%0t: power_result for %h^%h mod %h: expected %h, actual %h",
                        $time, oldest.base, oldest.exponent, oldest.modulus,
                        oldest.power, rsp_power_result);
               mismatch_count++;
            end
         end
      end
   end

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_modulus();
      test_out_of_range_modulus();
      test_field_extremes();
      test_random_phases();
      test_back_to_back();
      wait_for_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("Run covered %0d items under %0d modulus writes, moduli 0, 1, 2 and full range",
               items_sent, modulus_writes);
      $display("%0d results checked, stalls and gaps on both sides, then a back-to-back tail",
               results_checked);
      if (mismatch_count == 0 && pending_powers.size() == 0) begin
         $display("[modular_exponentiation] OK");
      end else begin
         $display("[modular_exponentiation] ERROR");
      end
      $finish;
   end

   // Hold a generous ceiling over the whole run
   initial begin
      #40_000_000;
      $display("%0t: timeout with %0d results outstanding", $time, pending_powers.size());
      $display("[modular_exponentiation] ERROR");
      $finish;
   end

endmodule : modular_exponentiation_tb

`default_nettype wire
